// ===== src/delta_sigma_dac_modulator_defines.svh =====
// ----------------------------------------------------------------------------
// Delta-sigma DAC modulator assertion macros
// Shared property wrappers for the concurrent checks of the modulator.
// ----------------------------------------------------------------------------
`ifndef DELTA_SIGMA_DAC_MODULATOR_DEFINES_SVH
`define DELTA_SIGMA_DAC_MODULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSDM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dsdm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSDM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dsdm next-cycle check failed");

`endif

// ===== src/dsdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta-sigma DAC modulator package
// Widths, constants, register indexes and shared types of the modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsdm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CODE_W     = 16;
    localparam int TAP_W      = 40;
    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 21;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int PACC_W     = 66;
    localparam int SUM_W      = 46;
    localparam int INT_W      = 32;
    localparam int COEF_FRAC  = 22;
    localparam int CHUNK_W    = 20;
    localparam int AMP_FRAC   = 6;
    localparam int MIX_FRAC   = 8;
    localparam int TAP_FRAC   = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int AMP_MAX    = 32767;
    localparam int OFFSET_BIN = 32768;

    localparam logic signed [TAP_W-1:0] TAP0_RESET = 40'sd8388608;
    localparam logic [INT_W-1:0]        QUANT_MASK = 32'hffff_ff00;
    localparam logic [CODE_W-1:0]       CODE_MAX   = 16'hffff;

    localparam logic [7:0]  AMP_GAIN_RESET   = 8'd64;
    localparam logic [23:0] MIX_GAIN_RESET   = 24'd65536;
    localparam logic [16:0] MIX_OFFSET_RESET = 17'd0;
    localparam logic [25:0] LPF_K_RESET      = 26'd4194304;
    localparam logic [25:0] LPF_COEF_RESET   = 26'd0;

    typedef enum logic [2:0] {
        REG_AMP_GAIN,
        REG_MIX_GAIN,
        REG_MIX_OFFSET,
        REG_LPF_K,
        REG_LPF_A1,
        REG_LPF_A2,
        REG_LPF_B1,
        REG_LPF_B2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  amp_gain;
        logic [23:0] mix_gain;
        logic [16:0] mix_offset;
        logic [25:0] lpf_k;
        logic [25:0] lpf_a1;
        logic [25:0] lpf_a2;
        logic [25:0] lpf_b1;
        logic [25:0] lpf_b2;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AMP_L,
        S_AMP_R,
        S_MONO,
        S_MIX,
        S_XOFS,
        S_SHIFT,
        S_MUL_LO,
        S_MUL_HI,
        S_PACC,
        S_PSUM,
        S_TSAT,
        S_ROUND,
        S_INTEG,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        TERM_K,
        TERM_A1,
        TERM_A2,
        TERM_B1,
        TERM_B2
    } t_term;

endpackage

`default_nettype wire

// ===== src/dsdm_mul.sv =====
// ----------------------------------------------------------------------------
// Delta-sigma modulator shared multiplier
// Signed 26 by 21 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdm_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [dsdm_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [dsdm_pkg::MUL_B_W-1:0] i_b,
    output logic signed [dsdm_pkg::PROD_W-1:0]       o_p
);

    logic signed [dsdm_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== src/dsdm_regs.sv =====
// ----------------------------------------------------------------------------
// Delta-sigma modulator configuration registers
// APB register file holding the amplifier, mix and filter settings.
// ----------------------------------------------------------------------------
`default_nettype none

module dsdm_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dsdm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [dsdm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dsdm_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    output dsdm_pkg::t_cfg                         o_cfg
);

    dsdm_pkg::t_cfg     r_cfg;
    dsdm_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign reg_idx = dsdm_pkg::t_reg_idx'(paddr[dsdm_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amp_gain   <= dsdm_pkg::AMP_GAIN_RESET;
            r_cfg.mix_gain   <= dsdm_pkg::MIX_GAIN_RESET;
            r_cfg.mix_offset <= dsdm_pkg::MIX_OFFSET_RESET;
            r_cfg.lpf_k      <= dsdm_pkg::LPF_K_RESET;
            r_cfg.lpf_a1     <= dsdm_pkg::LPF_COEF_RESET;
            r_cfg.lpf_a2     <= dsdm_pkg::LPF_COEF_RESET;
            r_cfg.lpf_b1     <= dsdm_pkg::LPF_COEF_RESET;
            r_cfg.lpf_b2     <= dsdm_pkg::LPF_COEF_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                dsdm_pkg::REG_AMP_GAIN:   r_cfg.amp_gain   <= pwdata[7:0];
                dsdm_pkg::REG_MIX_GAIN:   r_cfg.mix_gain   <= pwdata[23:0];
                dsdm_pkg::REG_MIX_OFFSET: r_cfg.mix_offset <= pwdata[16:0];
                dsdm_pkg::REG_LPF_K:      r_cfg.lpf_k      <= pwdata[25:0];
                dsdm_pkg::REG_LPF_A1:     r_cfg.lpf_a1     <= pwdata[25:0];
                dsdm_pkg::REG_LPF_A2:     r_cfg.lpf_a2     <= pwdata[25:0];
                dsdm_pkg::REG_LPF_B1:     r_cfg.lpf_b1     <= pwdata[25:0];
                dsdm_pkg::REG_LPF_B2:     r_cfg.lpf_b2     <= pwdata[25:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            dsdm_pkg::REG_AMP_GAIN:   prdata = 32'(r_cfg.amp_gain);
            dsdm_pkg::REG_MIX_GAIN:   prdata = 32'(r_cfg.mix_gain);
            dsdm_pkg::REG_MIX_OFFSET: prdata = 32'(r_cfg.mix_offset);
            dsdm_pkg::REG_LPF_K:      prdata = 32'(r_cfg.lpf_k);
            dsdm_pkg::REG_LPF_A1:     prdata = 32'(r_cfg.lpf_a1);
            dsdm_pkg::REG_LPF_A2:     prdata = 32'(r_cfg.lpf_a2);
            dsdm_pkg::REG_LPF_B1:     prdata = 32'(r_cfg.lpf_b1);
            dsdm_pkg::REG_LPF_B2:     prdata = 32'(r_cfg.lpf_b2);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/delta_sigma_dac_modulator.sv =====
// ----------------------------------------------------------------------------
// Delta-sigma DAC modulator
// Stereo to mono front end, biquad low-pass filter and wrapping integrator
// cascade producing OVERSAMPLE DAC codes for every input sample pair.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_left_sample, i_right_sample
//   output    out        o_out_valid / i_out_stall  o_dac_code, o_last
//   config    in         APB psel / penable         paddr, pwdata, prdata
//
// Every step uses the single shared multiplier, which runs two partial
// products for each of the five filter terms.
// The block takes no new transfer until the last code of the pair is loaded.
// Reset is synchronous and needs no clearing pass.
// A stalled output holds the sequencer only when the next code is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delta_sigma_dac_modulator_defines.svh"

module delta_sigma_dac_modulator #(
    parameter int OVERSAMPLE = 4,
    parameter int ORDER      = 3
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [dsdm_pkg::SAMPLE_W-1:0]   i_left_sample,
    input  wire logic signed [dsdm_pkg::SAMPLE_W-1:0]   i_right_sample,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [dsdm_pkg::CODE_W-1:0]                 o_dac_code,
    output logic                                        o_last,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [dsdm_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [dsdm_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [dsdm_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                        pready
);

    localparam int STEP_W  = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
    localparam int STAGE_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(OVERSAMPLE - 1);
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(ORDER - 1);

    localparam int TAP_W   = dsdm_pkg::TAP_W;
    localparam int SUM_W   = dsdm_pkg::SUM_W;
    localparam int PACC_W  = dsdm_pkg::PACC_W;
    localparam int PROD_W  = dsdm_pkg::PROD_W;
    localparam int INT_W   = dsdm_pkg::INT_W;
    localparam int CODE_W  = dsdm_pkg::CODE_W;
    localparam int SMP_W   = dsdm_pkg::SAMPLE_W;
    localparam int CHUNK_W = dsdm_pkg::CHUNK_W;

    function automatic logic [SMP_W-1:0] amp_code(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-dsdm_pkg::AMP_FRAC-1:0] v;
        logic signed [PROD_W-dsdm_pkg::AMP_FRAC-1:0] s;
        v = p[PROD_W-1:dsdm_pkg::AMP_FRAC];
        if (v > dsdm_pkg::AMP_MAX) begin
            s = (PROD_W - dsdm_pkg::AMP_FRAC)'(dsdm_pkg::AMP_MAX);
        end else if (v < -dsdm_pkg::AMP_MAX) begin
            s = (PROD_W - dsdm_pkg::AMP_FRAC)'(-dsdm_pkg::AMP_MAX);
        end else begin
            s = v;
        end
        s = s + (PROD_W - dsdm_pkg::AMP_FRAC)'(dsdm_pkg::OFFSET_BIN);
        return s[SMP_W-1:0];
    endfunction

    function automatic logic signed [TAP_W-1:0] sat_tap(input logic signed [SUM_W-1:0] s);
        logic fits;
        fits = (&s[SUM_W-1:TAP_W-1]) || !(|s[SUM_W-1:TAP_W-1]);
        if (fits) begin
            return s[TAP_W-1:0];
        end else if (s[SUM_W-1]) begin
            return {1'b1, {(TAP_W-1){1'b0}}};
        end else begin
            return {1'b0, {(TAP_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [INT_W-1:0] round_int(input logic signed [SUM_W-1:0] y);
        logic signed [SUM_W-1:0]                    t;
        logic [SUM_W-dsdm_pkg::TAP_FRAC-1:0]        w;
        logic                                       fits;
        t = y + SUM_W'(128);
        w = t[SUM_W-1:dsdm_pkg::TAP_FRAC];
        fits = (&w[SUM_W-dsdm_pkg::TAP_FRAC-1:INT_W-1])
            || !(|w[SUM_W-dsdm_pkg::TAP_FRAC-1:INT_W-1]);
        if (fits) begin
            return w[INT_W-1:0];
        end else if (w[SUM_W-dsdm_pkg::TAP_FRAC-1]) begin
            return {1'b1, {(INT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(INT_W-1){1'b1}}};
        end
    endfunction

    dsdm_pkg::t_cfg cfg;

    dsdm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic signed [dsdm_pkg::MUL_A_W-1:0] mul_a;
    logic signed [dsdm_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]            mul_p;

    dsdm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    dsdm_pkg::t_state r_state, n_state;
    dsdm_pkg::t_term  r_term, n_term;

    logic signed [SMP_W-1:0]  r_left, n_left;
    logic signed [SMP_W-1:0]  r_right, n_right;
    logic [SMP_W-1:0]         r_lcode, n_lcode;
    logic [SMP_W-1:0]         r_mono, n_mono;
    logic signed [TAP_W-1:0]  r_x, n_x;
    logic signed [TAP_W-1:0]  r_tap0, n_tap0;
    logic signed [TAP_W-1:0]  r_tap1, n_tap1;
    logic signed [TAP_W-1:0]  r_tap2, n_tap2;
    logic signed [PACC_W-1:0] r_pacc, n_pacc;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [INT_W-1:0]         r_v, n_v;
    logic [INT_W-1:0]         r_quant, n_quant;
    logic [INT_W-1:0]         r_integ [ORDER];
    logic [STAGE_W-1:0]       r_stage, n_stage;
    logic [STEP_W-1:0]        r_step, n_step;
    logic                     r_out_valid, n_out_valid;
    logic [CODE_W-1:0]        r_code, n_code;
    logic                     r_last, n_last;

    logic signed [dsdm_pkg::MUL_A_W-1:0]               coef;
    logic signed [TAP_W-1:0]                           tap_op;
    logic signed [PACC_W-dsdm_pkg::COEF_FRAC-1:0]      p_val;
    logic signed [SUM_W-1:0]                           p_ext;
    logic signed [PROD_W-dsdm_pkg::MIX_FRAC-1:0]       mix_q;
    logic signed [24:0]                                ofs_scaled;
    logic signed [TAP_W-1:0]                           tap0_sat;
    logic [INT_W-1:0]                                  integ_sum;
    logic                                              integ_we;
    logic [INT_W-1:0]                                  quant_new;
    logic [CODE_W-1:0]                                 code_clip;
    logic                                              in_take;
    logic                                              out_load;
    logic                                              step_last;

    assign in_take   = i_in_valid && (r_state == dsdm_pkg::S_IDLE);
    assign step_last = (r_step == LAST_STEP);
    assign out_load  = (r_state == dsdm_pkg::S_OUT) && (!r_out_valid || !i_out_stall);

    assign p_val      = r_pacc[PACC_W-1:dsdm_pkg::COEF_FRAC];
    assign p_ext      = SUM_W'(p_val);
    assign mix_q      = mul_p[PROD_W-1:dsdm_pkg::MIX_FRAC];
    assign ofs_scaled = {cfg.mix_offset, 8'b0};
    assign tap0_sat   = sat_tap(r_sum);
    assign integ_sum  = r_integ[r_stage] + r_v - r_quant;
    assign quant_new  = r_v & dsdm_pkg::QUANT_MASK;

    always_comb begin
        if (quant_new[INT_W-1]) begin
            code_clip = '0;
        end else if (|quant_new[INT_W-2:CODE_W]) begin
            code_clip = dsdm_pkg::CODE_MAX;
        end else begin
            code_clip = quant_new[CODE_W-1:0];
        end
    end

    always_comb begin
        case (r_term)
            dsdm_pkg::TERM_K: begin
                coef   = cfg.lpf_k;
                tap_op = r_x;
            end
            dsdm_pkg::TERM_A1: begin
                coef   = cfg.lpf_a1;
                tap_op = r_tap1;
            end
            dsdm_pkg::TERM_A2: begin
                coef   = cfg.lpf_a2;
                tap_op = r_tap2;
            end
            dsdm_pkg::TERM_B1: begin
                coef   = cfg.lpf_b1;
                tap_op = r_tap1;
            end
            dsdm_pkg::TERM_B2: begin
                coef   = cfg.lpf_b2;
                tap_op = r_tap2;
            end
            default: begin
                coef   = '0;
                tap_op = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsdm_pkg::S_IDLE;
            r_term      <= dsdm_pkg::TERM_K;
            r_stage     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_tap0      <= dsdm_pkg::TAP0_RESET;
            r_tap1      <= '0;
            r_tap2      <= '0;
            r_quant     <= '0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_stage     <= n_stage;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_tap0      <= n_tap0;
            r_tap1      <= n_tap1;
            r_tap2      <= n_tap2;
            r_quant     <= n_quant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_integ[i] <= '0;
            end
        end else if (integ_we) begin
            r_integ[r_stage] <= integ_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        r_lcode <= n_lcode;
        r_mono  <= n_mono;
        r_x     <= n_x;
        r_pacc  <= n_pacc;
        r_sum   <= n_sum;
        r_v     <= n_v;
        r_code  <= n_code;
        r_last  <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_left      = r_left;
        n_right     = r_right;
        n_lcode     = r_lcode;
        n_mono      = r_mono;
        n_x         = r_x;
        n_tap0      = r_tap0;
        n_tap1      = r_tap1;
        n_tap2      = r_tap2;
        n_pacc      = r_pacc;
        n_sum       = r_sum;
        n_v         = r_v;
        n_quant     = r_quant;
        n_stage     = r_stage;
        n_step      = r_step;
        n_code      = r_code;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        integ_we    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        case (r_state)
            dsdm_pkg::S_IDLE: begin
                if (in_take) begin
                    n_left  = i_left_sample;
                    n_right = i_right_sample;
                    n_state = dsdm_pkg::S_AMP_L;
                end
            end
            dsdm_pkg::S_AMP_L: begin
                mul_a   = dsdm_pkg::MUL_A_W'(r_left);
                mul_b   = {13'b0, cfg.amp_gain};
                n_state = dsdm_pkg::S_AMP_R;
            end
            dsdm_pkg::S_AMP_R: begin
                mul_a   = dsdm_pkg::MUL_A_W'(r_right);
                mul_b   = {13'b0, cfg.amp_gain};
                n_lcode = amp_code(mul_p);
                n_state = dsdm_pkg::S_MONO;
            end
            dsdm_pkg::S_MONO: begin
                n_mono  = SMP_W'(({1'b0, r_lcode} + {1'b0, amp_code(mul_p)}) >> 1);
                n_state = dsdm_pkg::S_MIX;
            end
            dsdm_pkg::S_MIX: begin
                mul_a   = {2'b0, cfg.mix_gain};
                mul_b   = {5'b0, r_mono};
                n_state = dsdm_pkg::S_XOFS;
            end
            dsdm_pkg::S_XOFS: begin
                n_x     = TAP_W'(mix_q) + TAP_W'(ofs_scaled);
                n_state = dsdm_pkg::S_SHIFT;
            end
            dsdm_pkg::S_SHIFT: begin
                n_tap2  = r_tap1;
                n_tap1  = r_tap0;
                n_term  = dsdm_pkg::TERM_K;
                n_state = dsdm_pkg::S_MUL_LO;
            end
            dsdm_pkg::S_MUL_LO: begin
                mul_a   = coef;
                mul_b   = {1'b0, tap_op[CHUNK_W-1:0]};
                n_state = dsdm_pkg::S_MUL_HI;
            end
            dsdm_pkg::S_MUL_HI: begin
                mul_a   = coef;
                mul_b   = {tap_op[TAP_W-1], tap_op[TAP_W-1:CHUNK_W]};
                n_pacc  = PACC_W'(mul_p);
                n_state = dsdm_pkg::S_PACC;
            end
            dsdm_pkg::S_PACC: begin
                n_pacc  = r_pacc + (PACC_W'(mul_p) <<< CHUNK_W);
                n_state = dsdm_pkg::S_PSUM;
            end
            dsdm_pkg::S_PSUM: begin
                case (r_term)
                    dsdm_pkg::TERM_K: begin
                        n_sum   = p_ext;
                        n_term  = dsdm_pkg::TERM_A1;
                        n_state = dsdm_pkg::S_MUL_LO;
                    end
                    dsdm_pkg::TERM_A1: begin
                        n_sum   = r_sum - p_ext;
                        n_term  = dsdm_pkg::TERM_A2;
                        n_state = dsdm_pkg::S_MUL_LO;
                    end
                    dsdm_pkg::TERM_A2: begin
                        n_sum   = r_sum - p_ext;
                        n_state = dsdm_pkg::S_TSAT;
                    end
                    dsdm_pkg::TERM_B1: begin
                        n_sum   = r_sum + p_ext;
                        n_term  = dsdm_pkg::TERM_B2;
                        n_state = dsdm_pkg::S_MUL_LO;
                    end
                    dsdm_pkg::TERM_B2: begin
                        n_sum   = r_sum + p_ext;
                        n_state = dsdm_pkg::S_ROUND;
                    end
                    default: begin
                        n_state = dsdm_pkg::S_IDLE;
                    end
                endcase
            end
            dsdm_pkg::S_TSAT: begin
                n_tap0  = tap0_sat;
                n_sum   = SUM_W'(tap0_sat);
                n_term  = dsdm_pkg::TERM_B1;
                n_state = dsdm_pkg::S_MUL_LO;
            end
            dsdm_pkg::S_ROUND: begin
                n_v     = round_int(r_sum);
                n_stage = '0;
                n_state = dsdm_pkg::S_INTEG;
            end
            dsdm_pkg::S_INTEG: begin
                integ_we = 1'b1;
                n_v      = integ_sum;
                if (r_stage == LAST_STAGE) begin
                    n_state = dsdm_pkg::S_OUT;
                end else begin
                    n_stage = r_stage + 1'b1;
                end
            end
            dsdm_pkg::S_OUT: begin
                if (out_load) begin
                    n_quant     = quant_new;
                    n_code      = code_clip;
                    n_last      = step_last;
                    n_out_valid = 1'b1;
                    if (step_last) begin
                        n_step  = '0;
                        n_state = dsdm_pkg::S_IDLE;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = dsdm_pkg::S_SHIFT;
                    end
                end
            end
            default: begin
                n_state = dsdm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != dsdm_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_dac_code  = r_code;
    assign o_last      = r_last;

    `DSDM_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `DSDM_ASSERT_IMPL(a_code_grid, i_clk, i_rst_n, o_out_valid, (o_dac_code[7:0] == 8'h00) || (o_dac_code == dsdm_pkg::CODE_MAX))
    `DSDM_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, out_load && step_last, (r_state == dsdm_pkg::S_IDLE) && (r_step == '0) && o_last)
    `DSDM_ASSERT_IMPL(a_stage_range, i_clk, i_rst_n, r_state == dsdm_pkg::S_INTEG, r_stage <= LAST_STAGE)

endmodule

`default_nettype wire

// ===== sim/delta_sigma_dac_modulator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delta-sigma DAC modulator testbench
// Sends stereo sample pairs through the input channel under random gaps and
// output stalls. Register settings change between phases over the APB port.
// A local fixed-point model of the amplifier, mixer, biquad and integrator
// cascade predicts every DAC code, and each code is checked in order.
// ----------------------------------------------------------------------------
module delta_sigma_dac_modulator_test;

    localparam int OVERSAMPLE = 4;
    localparam int ORDER      = 3;
    localparam int NUM_PHASES = 12;

    localparam int SAMPLE_W   = dsdm_pkg::SAMPLE_W;
    localparam int CODE_W     = dsdm_pkg::CODE_W;
    localparam int APB_ADDR_W = dsdm_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = dsdm_pkg::APB_DATA_W;
    localparam int MUL_A_W    = dsdm_pkg::MUL_A_W;

    localparam longint TAP_MAX = (longint'(1) <<< (dsdm_pkg::TAP_W - 1)) - 1;
    localparam longint TAP_MIN = -TAP_MAX - 1;
    localparam longint N_MAX   = (longint'(1) <<< (dsdm_pkg::INT_W - 1)) - 1;
    localparam longint N_MIN   = -N_MAX - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_pair;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_code;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_left_sample = '0;
    logic signed [SAMPLE_W-1:0] i_right_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [CODE_W-1:0]          o_dac_code;
    logic                       o_last;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    t_pair  pairs_q[$];
    t_code  codes_q[$];
    int     error_count = 0;
    int     in_gap = 0;
    int     stall_left = 0;
    logic   in_fire = 1'b0;
    logic   idle_on = 1'b1;

    // Model state.
    dsdm_pkg::t_cfg model_cfg;
    longint         taps[3];
    logic [31:0]    quant;
    logic [31:0]    integ[3];

    delta_sigma_dac_modulator #(
        .OVERSAMPLE(OVERSAMPLE),
        .ORDER(ORDER)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_left_sample(i_left_sample),
        .i_right_sample(i_right_sample),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_dac_code(o_dac_code),
        .o_last(o_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floor(c * t / 2^22), computed exactly at full width.
    function automatic longint coef_mul(input logic signed [MUL_A_W-1:0] c,
                                        input longint t);
        logic signed [127:0] cw;
        logic signed [127:0] tw;
        logic signed [127:0] p;
        cw = c;
        tw = t;
        p = cw * tw;
        return longint'(p >>> dsdm_pkg::COEF_FRAC);
    endfunction

    function automatic longint amp_stage(input logic signed [SAMPLE_W-1:0] s);
        longint v;
        v = (longint'(s) * longint'(model_cfg.amp_gain)) >>> dsdm_pkg::AMP_FRAC;
        return clamp(v, -dsdm_pkg::AMP_MAX, dsdm_pkg::AMP_MAX) + dsdm_pkg::OFFSET_BIN;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (r < 5) return 16'($urandom());
        return 16'($urandom_range(0, 4095)) - 16'd2048;
    endfunction

    function automatic logic [APB_DATA_W-1:0] cfg_word(input dsdm_pkg::t_reg_idx idx);
        case (idx)
            dsdm_pkg::REG_AMP_GAIN:   return 32'(model_cfg.amp_gain);
            dsdm_pkg::REG_MIX_GAIN:   return 32'(model_cfg.mix_gain);
            dsdm_pkg::REG_MIX_OFFSET: return 32'(model_cfg.mix_offset);
            dsdm_pkg::REG_LPF_K:      return 32'(model_cfg.lpf_k);
            dsdm_pkg::REG_LPF_A1:     return 32'(model_cfg.lpf_a1);
            dsdm_pkg::REG_LPF_A2:     return 32'(model_cfg.lpf_a2);
            dsdm_pkg::REG_LPF_B1:     return 32'(model_cfg.lpf_b1);
            dsdm_pkg::REG_LPF_B2:     return 32'(model_cfg.lpf_b2);
            default:                  return '0;
        endcase
    endfunction

    task automatic model_reset();
        model_cfg.amp_gain   = dsdm_pkg::AMP_GAIN_RESET;
        model_cfg.mix_gain   = dsdm_pkg::MIX_GAIN_RESET;
        model_cfg.mix_offset = dsdm_pkg::MIX_OFFSET_RESET;
        model_cfg.lpf_k      = dsdm_pkg::LPF_K_RESET;
        model_cfg.lpf_a1     = dsdm_pkg::LPF_COEF_RESET;
        model_cfg.lpf_a2     = dsdm_pkg::LPF_COEF_RESET;
        model_cfg.lpf_b1     = dsdm_pkg::LPF_COEF_RESET;
        model_cfg.lpf_b2     = dsdm_pkg::LPF_COEF_RESET;
        taps[0] = dsdm_pkg::TAP0_RESET;
        taps[1] = 0;
        taps[2] = 0;
        quant = '0;
        for (int s = 0; s < 3; s++) integ[s] = '0;
    endtask

    task automatic modulate_pair(input logic signed [SAMPLE_W-1:0] left,
                                 input logic signed [SAMPLE_W-1:0] right);
        longint mono;
        longint x;
        longint y;
        longint n;
        longint q;
        logic [31:0] v;
        t_code c;
        mono = (amp_stage(left) + amp_stage(right)) >>> 1;
        x = ((mono * longint'(model_cfg.mix_gain)) >>> dsdm_pkg::MIX_FRAC)
            + longint'($signed(model_cfg.mix_offset)) * 256;
        for (int j = 0; j < OVERSAMPLE; j++) begin
            taps[2] = taps[1];
            taps[1] = taps[0];
            taps[0] = clamp(coef_mul(model_cfg.lpf_k, x)
                            - coef_mul(model_cfg.lpf_a1, taps[1])
                            - coef_mul(model_cfg.lpf_a2, taps[2]), TAP_MIN, TAP_MAX);
            y = taps[0] + coef_mul(model_cfg.lpf_b1, taps[1])
                + coef_mul(model_cfg.lpf_b2, taps[2]);
            n = clamp((y + 128) >>> dsdm_pkg::TAP_FRAC, N_MIN, N_MAX);
            v = 32'(n);
            for (int s = 0; s < ORDER; s++) begin
                integ[s] = integ[s] + v - quant;
                v = integ[s];
            end
            quant = v & dsdm_pkg::QUANT_MASK;
            q = clamp(longint'($signed(quant)), 0, dsdm_pkg::CODE_MAX);
            c.code = q[CODE_W-1:0];
            c.last = (j == OVERSAMPLE - 1);
            codes_q.push_back(c);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic apb_write(input dsdm_pkg::t_reg_idx idx,
                             input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] rd;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            dsdm_pkg::REG_AMP_GAIN:   model_cfg.amp_gain   = data[7:0];
            dsdm_pkg::REG_MIX_GAIN:   model_cfg.mix_gain   = data[23:0];
            dsdm_pkg::REG_MIX_OFFSET: model_cfg.mix_offset = data[16:0];
            dsdm_pkg::REG_LPF_K:      model_cfg.lpf_k      = data[25:0];
            dsdm_pkg::REG_LPF_A1:     model_cfg.lpf_a1     = data[25:0];
            dsdm_pkg::REG_LPF_A2:     model_cfg.lpf_a2     = data[25:0];
            dsdm_pkg::REG_LPF_B1:     model_cfg.lpf_b1     = data[25:0];
            dsdm_pkg::REG_LPF_B2:     model_cfg.lpf_b2     = data[25:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (rd !== cfg_word(idx))
            report_mismatch("register readback", int'(rd), int'(cfg_word(idx)));
    endtask

    // Unused upper bits carry random junk, which the block must drop.
    task automatic load_setting(input dsdm_pkg::t_cfg s);
        apb_write(dsdm_pkg::REG_AMP_GAIN,   {24'($urandom()), s.amp_gain});
        apb_write(dsdm_pkg::REG_MIX_GAIN,   {8'($urandom()), s.mix_gain});
        apb_write(dsdm_pkg::REG_MIX_OFFSET, {15'($urandom()), s.mix_offset});
        apb_write(dsdm_pkg::REG_LPF_K,      {6'($urandom()), s.lpf_k});
        apb_write(dsdm_pkg::REG_LPF_A1,     {6'($urandom()), s.lpf_a1});
        apb_write(dsdm_pkg::REG_LPF_A2,     {6'($urandom()), s.lpf_a2});
        apb_write(dsdm_pkg::REG_LPF_B1,     {6'($urandom()), s.lpf_b1});
        apb_write(dsdm_pkg::REG_LPF_B2,     {6'($urandom()), s.lpf_b2});
    endtask

    always @(negedge i_clk) begin : pair_driver
        t_pair p;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pairs_q.size() != 0) begin
                p = pairs_q.pop_front();
                i_left_sample <= p.left;
                i_right_sample <= p.right;
                i_in_valid <= 1'b1;
                in_gap <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : out_stall_driver
        int n;
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            n = pick_gap();
            i_out_stall <= (n > 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge i_clk) begin : code_monitor
        t_code want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (codes_q.size() == 0) begin
                    report_mismatch("unexpected code", o_dac_code, 0);
                end else begin
                    want = codes_q.pop_front();
                    if (o_dac_code !== want.code)
                        report_mismatch("dac_code", o_dac_code, want.code);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
            end
            in_fire = i_in_valid && !o_in_stall;
            if (in_fire) modulate_pair(i_left_sample, i_right_sample);
        end else begin
            in_fire = 1'b0;
        end
    end

    initial begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        dsdm_pkg::t_cfg setting;
        int   num_random;
        t_pair p;
        logic signed [SAMPLE_W-1:0] dir_l[12];
        logic signed [SAMPLE_W-1:0] dir_r[12];
        dir_l = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd1,
                  -16'sd1, 16'sd16384, 16'sh5555, 16'shaaaa, 16'sh8000, 16'sh8000};
        dir_r = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0,
                  -16'sd1, -16'sd16384, 16'shaaaa, 16'sh5555, 16'sh8000, 16'sh8000};
        model_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            setting = model_cfg;
            num_random = 25;
            case (phase)
                0: num_random = 0;
                1: begin
                    setting = '{8'hff, 24'hffffff, 17'h0ffff, 26'h1ffffff,
                                26'h2000000, 26'h1ffffff, 26'h2000000, 26'h1ffffff};
                    num_random = 0;
                end
                2: begin
                    setting = '{8'h00, 24'h000000, 17'h10000, 26'h2000000,
                                26'h1ffffff, 26'h2000000, 26'h1ffffff, 26'h2000000};
                    num_random = 0;
                end
                3: begin
                    setting = '{8'hff, dsdm_pkg::MIX_GAIN_RESET, dsdm_pkg::MIX_OFFSET_RESET,
                                dsdm_pkg::LPF_K_RESET, dsdm_pkg::LPF_COEF_RESET,
                                dsdm_pkg::LPF_COEF_RESET, dsdm_pkg::LPF_COEF_RESET,
                                dsdm_pkg::LPF_COEF_RESET};
                    num_random = 0;
                end
                4: setting = '{dsdm_pkg::AMP_GAIN_RESET, dsdm_pkg::MIX_GAIN_RESET,
                               dsdm_pkg::MIX_OFFSET_RESET,
                               26'd2097152, -26'sd2097152, 26'd0, 26'd0, 26'd0};
                5: setting = '{8'd48, 24'd60000, 17'd1024, 26'd838861, -26'sd5033165,
                               26'd1677722, 26'd1677722, 26'd838861};
                6: begin
                    setting.amp_gain   = 8'($urandom());
                    setting.mix_gain   = 24'($urandom());
                    setting.mix_offset = 17'($urandom());
                    setting.lpf_k      = 26'($urandom());
                    setting.lpf_a1     = 26'($urandom());
                    setting.lpf_a2     = 26'($urandom());
                    setting.lpf_b1     = 26'($urandom());
                    setting.lpf_b2     = 26'($urandom());
                end
                default: begin
                    setting.amp_gain   = 8'($urandom_range(16, 192));
                    setting.mix_gain   = 24'($urandom_range(16384, 131072));
                    setting.mix_offset = 17'($urandom_range(0, 16383)) - 17'd8192;
                    setting.lpf_k      = 26'($urandom_range(0, 4194304));
                    setting.lpf_a1     = 26'd0 - 26'($urandom_range(0, 6000000));
                    setting.lpf_a2     = 26'($urandom_range(0, 2097152));
                    setting.lpf_b1     = 26'($urandom_range(0, 4194304)) - 26'd2097152;
                    setting.lpf_b2     = 26'($urandom_range(0, 4194304)) - 26'd2097152;
                end
            endcase
            if (phase != 0) load_setting(setting);
            idle_on = (phase % 4) != 3;

            if (phase == 0) begin
                for (int i = 0; i < 12; i++) begin
                    p.left = dir_l[i];
                    p.right = dir_r[i];
                    pairs_q.push_back(p);
                end
            end else if (phase < 4) begin
                for (int i = 1; i < 5; i++) begin
                    p.left = dir_l[i];
                    p.right = dir_r[i];
                    pairs_q.push_back(p);
                end
            end
            for (int i = 0; i < num_random; i++) begin
                p.left = rand_sample();
                p.right = ($urandom_range(0, 3) == 0) ? p.left : rand_sample();
                pairs_q.push_back(p);
            end

            @(posedge i_clk);
            while (pairs_q.size() != 0 || i_in_valid) @(posedge i_clk);
            while (codes_q.size() != 0) @(posedge i_clk);
            repeat (8) @(posedge i_clk);
        end

        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
